FILE: src/cursor_array_list_assert.svh
// Assertion macros for the cursor array list.
// Relies on clk_i and rst_ni being visible where a macro is used.
`ifndef CURSOR_ARRAY_LIST_ASSERT_SVH
`define CURSOR_ARRAY_LIST_ASSERT_SVH

// same-cycle implication
`define CAL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cursor_array_list check failed");

// next-cycle implication
`define CAL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cursor_array_list check failed");

`endif

FILE: src/cal_pkg.sv
// Shared types and codes for the cursor array list.
// No dependencies; used by cal_core, cursor_array_list and cal_checker.
`default_nettype none

package cal_pkg;

  localparam logic [6:0] LIMIT_RESET = 7'd64;

  typedef enum logic [3:0] {
    RQ_INSERT = 4'd0,
    RQ_APPEND = 4'd1,
    RQ_REMOVE = 4'd2,
    RQ_READ   = 4'd3,
    RQ_SET    = 4'd4,
    RQ_NEXT   = 4'd5,
    RQ_PREV   = 4'd6,
    RQ_START  = 4'd7,
    RQ_END    = 4'd8,
    RQ_CLEAR  = 4'd9,
    RQ_FIND   = 4'd10
  } cal_req_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NO_ELEM   = 3'd3,
    ST_BAD_INDEX = 3'd4,
    ST_BOUNDARY  = 3'd5,
    ST_NOT_FOUND = 3'd6
  } cal_status_e;

  typedef struct packed {
    logic [3:0]         req_type;
    logic signed [31:0] value;
    logic [5:0]         index;
  } cal_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] element;
    logic [6:0]         position;
    logic [6:0]         count;
  } cal_res_t;

endpackage

`default_nettype wire

FILE: src/cal_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/cal_core.sv
// Sequencer and datapath of the cursor array list: count, cursor, walk index
// and one compare unit over a single-port-pair RAM. Uses cal_pkg and cal_ram.
`default_nettype none

module cal_core #(
  parameter int CAPACITY      = 64,
  parameter int ELEMENT_WIDTH = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [6:0]        limit_i,
  input  wire logic              req_valid_i,
  output logic                   req_ready_o,
  input  wire cal_pkg::cal_req_t req_i,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output cal_pkg::cal_res_t      res_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int LW = (CW > 7) ? CW : 7;
  localparam int EW = ELEMENT_WIDTH;
  localparam int MW = (EW < 32) ? EW : 32;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SHIFT = 5'b00010,
    S_FIND  = 5'b00100,
    S_ELEM  = 5'b01000,
    S_RESP  = 5'b10000
  } cal_state_e;

  cal_state_e          state_q, state_d;
  logic [CW-1:0]       fill_q, fill_d;
  logic [CW-1:0]       cursor_q, cursor_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic                pend_q, pend_d;
  logic                ins_q, ins_d;
  logic                find_q, find_d;
  cal_pkg::cal_status_e status_q, status_d;
  logic [EW-1:0]       val_q, val_d;
  logic [AW-1:0]       dst_q, dst_d;
  logic [CW-1:0]       fpos_q, fpos_d;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [EW-1:0]       ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [EW-1:0]       rdata;

  logic [EW-1:0]       val_ext;
  logic [31:0]         elem_ext;
  logic [LW-1:0]       lim;
  logic                full;
  logic [CW-1:0]       idx_prev;
  logic [CW:0]         idx_next;
  logic                more;
  logic [LW-1:0]       pos_w;
  logic [LW-1:0]       cnt_w;

  always_comb begin
    val_ext = '0;
    val_ext[MW-1:0] = req_i.value[MW-1:0];
    elem_ext = '0;
    elem_ext[MW-1:0] = rdata[MW-1:0];
  end

  assign lim  = (LW'(limit_i) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(limit_i);
  assign full = LW'(fill_q) >= lim;

  assign idx_prev = idx_q - 1'b1;
  assign idx_next = {1'b0, idx_q} + 1'b1;
  // insert walks down to the cursor, remove walks up to the last entry
  assign more = ins_q ? (idx_q != cursor_q) : (idx_next < {1'b0, fill_q});

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    cursor_d  = cursor_q;
    idx_d     = idx_q;
    pend_d    = pend_q;
    ins_d     = ins_q;
    find_d    = find_q;
    status_d  = status_q;
    val_d     = val_q;
    dst_d     = dst_q;
    fpos_d    = fpos_q;
    ram_we    = 1'b0;
    ram_waddr = dst_q;
    ram_wdata = rdata;
    ram_re    = 1'b0;
    ram_raddr = '0;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          val_d    = val_ext;
          find_d   = 1'b0;
          status_d = cal_pkg::ST_OK;
          state_d  = S_ELEM;
          case (req_i.req_type)
            cal_pkg::RQ_INSERT: begin
              if (full) begin
                status_d = cal_pkg::ST_FULL;
              end else begin
                idx_d   = fill_q;
                ins_d   = 1'b1;
                pend_d  = 1'b0;
                state_d = S_SHIFT;
              end
            end
            cal_pkg::RQ_APPEND: begin
              if (full) begin
                status_d = cal_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = fill_q[AW-1:0];
                ram_wdata = val_ext;
                fill_d    = fill_q + 1'b1;
              end
            end
            cal_pkg::RQ_REMOVE: begin
              if (fill_q == '0) begin
                status_d = cal_pkg::ST_EMPTY;
              end else if (cursor_q >= fill_q) begin
                status_d = cal_pkg::ST_NO_ELEM;
              end else begin
                idx_d   = cursor_q;
                ins_d   = 1'b0;
                pend_d  = 1'b0;
                state_d = S_SHIFT;
              end
            end
            cal_pkg::RQ_READ: begin
              if (fill_q == '0) begin
                status_d = cal_pkg::ST_EMPTY;
              end else if (cursor_q >= fill_q) begin
                status_d = cal_pkg::ST_NO_ELEM;
              end
            end
            cal_pkg::RQ_SET: begin
              if (LW'(req_i.index) < LW'(fill_q)) begin
                cursor_d = CW'(req_i.index);
              end else begin
                status_d = cal_pkg::ST_BAD_INDEX;
              end
            end
            cal_pkg::RQ_NEXT: begin
              if (cursor_q >= fill_q) begin
                status_d = cal_pkg::ST_BOUNDARY;
              end else begin
                cursor_d = cursor_q + 1'b1;
              end
            end
            cal_pkg::RQ_PREV: begin
              if (cursor_q == '0) begin
                status_d = cal_pkg::ST_BOUNDARY;
              end else begin
                cursor_d = cursor_q - 1'b1;
              end
            end
            cal_pkg::RQ_START: begin
              if (cursor_q == '0) begin
                status_d = cal_pkg::ST_BOUNDARY;
              end else begin
                cursor_d = '0;
              end
            end
            cal_pkg::RQ_END: begin
              if (cursor_q == fill_q) begin
                status_d = cal_pkg::ST_BOUNDARY;
              end else begin
                cursor_d = fill_q;
              end
            end
            cal_pkg::RQ_CLEAR: begin
              fill_d   = '0;
              cursor_d = '0;
            end
            cal_pkg::RQ_FIND: begin
              idx_d   = '0;
              pend_d  = 1'b0;
              find_d  = 1'b1;
              state_d = S_FIND;
            end
            default: begin
              status_d = cal_pkg::ST_BAD_INDEX;
            end
          endcase
        end
      end

      S_SHIFT: begin
        // word read last cycle lands one place over
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = dst_q;
          ram_wdata = rdata;
        end
        if (more) begin
          ram_re    = 1'b1;
          ram_raddr = ins_q ? idx_prev[AW-1:0] : idx_next[AW-1:0];
          dst_d     = idx_q[AW-1:0];
          pend_d    = 1'b1;
          idx_d     = ins_q ? idx_prev : idx_next[CW-1:0];
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          if (ins_q) begin
            ram_we    = 1'b1;
            ram_waddr = cursor_q[AW-1:0];
            ram_wdata = val_q;
            fill_d    = fill_q + 1'b1;
          end else begin
            fill_d = fill_q - 1'b1;
          end
          state_d = S_ELEM;
        end
      end

      S_FIND: begin
        if (pend_q && (rdata == val_q)) begin
          status_d = cal_pkg::ST_OK;
          fpos_d   = CW'(dst_q);
          pend_d   = 1'b0;
          state_d  = S_ELEM;
        end else if (idx_q < fill_q) begin
          ram_re    = 1'b1;
          ram_raddr = idx_q[AW-1:0];
          dst_d     = idx_q[AW-1:0];
          pend_d    = 1'b1;
          idx_d     = idx_next[CW-1:0];
        end else begin
          status_d = cal_pkg::ST_NOT_FOUND;
          fpos_d   = fill_q;
          pend_d   = 1'b0;
          state_d  = S_ELEM;
        end
      end

      S_ELEM: begin
        // address wraps when the cursor sits at capacity; data unused then
        ram_re    = 1'b1;
        ram_raddr = cursor_q[AW-1:0];
        state_d   = S_RESP;
      end

      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fill_q   <= '0;
      cursor_q <= '0;
      idx_q    <= '0;
      pend_q   <= 1'b0;
      ins_q    <= 1'b0;
      find_q   <= 1'b0;
      status_q <= cal_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      cursor_q <= cursor_d;
      idx_q    <= idx_d;
      pend_q   <= pend_d;
      ins_q    <= ins_d;
      find_q   <= find_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    dst_q  <= dst_d;
    fpos_q <= fpos_d;
  end

  cal_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_cal_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  assign pos_w = find_q ? LW'(fpos_q) : LW'(cursor_q);
  assign cnt_w = LW'(fill_q);

  assign req_ready_o    = (state_q == S_IDLE);
  assign res_valid_o    = (state_q == S_RESP);
  assign res_o.status   = status_q;
  assign res_o.element  = (cursor_q < fill_q) ? elem_ext : '1;
  assign res_o.position = pos_w[6:0];
  assign res_o.count    = cnt_w[6:0];

endmodule

`default_nettype wire

FILE: src/cursor_array_list.sv
// Cursor array list: a list of up to CAPACITY words with a cursor, driven by
// one request at a time. Read, append, cursor moves, clear and rejected
// requests pass through the element read state and the response state into
// the output register. Insert first moves each word from the cursor onward
// one place up and then writes the new word at the cursor; remove moves each
// word after the cursor one place down. Find compares words from index zero
// until a hit or the end of the list. The list RAM moves or compares one word
// per cycle. A new request is taken once the previous result has moved into
// the output register, even if that word is not yet collected. Stored words
// need no clearing after reset. Depends on cal_pkg and cal_core.
`default_nettype none

module cursor_array_list #(
  parameter int CAPACITY      = 64,
  parameter int ELEMENT_WIDTH = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [6:0]        cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire cal_pkg::cal_req_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output cal_pkg::cal_res_t      out_data_o
);

  logic [6:0]        limit_q, limit_d;
  logic              out_valid_q, out_valid_d;
  cal_pkg::cal_res_t out_data_q, out_data_d;
  logic              res_valid;
  logic              res_ready;
  cal_pkg::cal_res_t res;

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    limit_d     = cfg_we_i ? cfg_wdata_i : limit_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_data_d  = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= cal_pkg::LIMIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      limit_q     <= limit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  cal_core #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_cal_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_i     (limit_q),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_i       (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

FILE: src/cal_checker.sv
// Port-level checks for the cursor array list, bound to the top level.
// Depends on cal_pkg and cursor_array_list_assert.svh.
`default_nettype none
`include "cursor_array_list_assert.svh"

module cal_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire cal_pkg::cal_res_t out_data_o
);

  // a held result word must not move
  `CAL_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // one request at a time: busy right after taking a word
  `CAL_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

  `CAL_ASSERT_NOW(a_empty_count, out_valid_o && (out_data_o.status == cal_pkg::ST_EMPTY), out_data_o.count == 7'd0)

  `CAL_ASSERT_NOW(a_miss_pos, out_valid_o && (out_data_o.status == cal_pkg::ST_NOT_FOUND), out_data_o.position == out_data_o.count)

  `CAL_ASSERT_NOW(a_empty_elem, out_valid_o && (out_data_o.count == 7'd0), out_data_o.element == 32'hFFFF_FFFF)

endmodule

bind cursor_array_list cal_checker u_cal_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
